### sv/mstk_pkg.sv
// Package with the shared types and codes of the max stack.
`timescale 1ns / 1ps
`default_nettype none

package mstk_pkg;

  // Operation codes carried in the action field of an input transaction.
  typedef enum logic [1:0] {
    ACT_PUSH    = 2'd0,
    ACT_POP     = 2'd1,
    ACT_POP_MAX = 2'd2
  } action_e;

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  // Operation selected by the controller when it takes a transaction.
  typedef enum logic [2:0] {
    OP_NOP,
    OP_PUSH,
    OP_POP,
    OP_POP_MAX,
    OP_ERR_EMPTY,
    OP_ERR_FULL
  } op_e;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEED,
    ST_SWEEP,
    ST_RESP
  } state_e;

  // Input transaction payload.
  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] value;
  } in_t;

  // Output transaction payload.
  typedef struct packed {
    logic signed [31:0] removed_value;
    logic signed [31:0] top_value;
    logic signed [31:0] max_value;
    logic [6:0]         fill_level;
    status_e            status;
  } out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // take the input transaction and start the operation
    op_e  op;        // decoded operation, valid with load
    logic seed;      // capture the entry below the removed one
    logic step;      // move one entry down by one place
    logic issue;     // read the next entry of the sweep
    logic out_load;  // copy the result into the output register
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;     // no entry held
    logic full;      // every entry held
    logic more;      // an entry above the gap is still to be moved
  } dp_status_t;

endpackage

`default_nettype wire

### sv/max_stack_top.sv
// Top level of the max stack: controller, datapath and their connections.
`timescale 1ns / 1ps
`default_nettype none

// Bounded stack of signed 32-bit values with push, pop and pop-max; every
// transaction returns the removed value, the new top, the new maximum, the
// fill level and a status. Each entry is kept in a single-port-read RAM
// together with the maximum of itself and the entries below it, so the top
// and the maximum are always in registers. A push, a faulted operation or an
// unused action goes from idle straight to the response state; a pop first
// passes the seed state; a pop-max also sweeps the entries above the removed
// one, because the entries that close the gap are moved down one per cycle
// through the RAM read port. A result also waits while the output register
// still holds an untaken transaction. No clearing pass is needed after reset.
module max_stack_top #(
  parameter int STACK_DEPTH = 64
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire mstk_pkg::in_t    in_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output mstk_pkg::out_t        out_o
);

  mstk_pkg::ctrl_cmd_t  cmd;
  mstk_pkg::dp_status_t dp_status;

  mstk_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .action_i    (in_i.action),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (dp_status),
    .cmd_o       (cmd)
  );

  mstk_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .cmd_i    (cmd),
    .status_o (dp_status),
    .out_o    (out_o)
  );

endmodule

`default_nettype wire

### sv/mstk_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module mstk_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                            clk_i,
  input  wire logic                            we_i,
  input  wire logic [$clog2(DEPTH)-1:0]        waddr_i,
  input  wire logic [WIDTH-1:0]                wdata_i,
  input  wire logic                            re_i,
  input  wire logic [$clog2(DEPTH)-1:0]        raddr_i,
  output logic      [WIDTH-1:0]                rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

### sv/mstk_ctrl.sv
// Controller state machine of the max stack.
`timescale 1ns / 1ps
`default_nettype none

module mstk_ctrl (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic [1:0]             action_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  input  wire mstk_pkg::dp_status_t   status_i,
  output mstk_pkg::ctrl_cmd_t         cmd_o
);

  mstk_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;

  // State and output valid registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mstk_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    cmd_o.op     = mstk_pkg::OP_NOP;
    in_ready_o   = 1'b0;
    out_valid_d  = out_valid_q && !out_ready_i;
    unique case (state_q)
      mstk_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          priority if (action_i == mstk_pkg::ACT_PUSH) begin
            cmd_o.op = status_i.full ? mstk_pkg::OP_ERR_FULL : mstk_pkg::OP_PUSH;
          end else if (action_i == mstk_pkg::ACT_POP) begin
            cmd_o.op = status_i.empty ? mstk_pkg::OP_ERR_EMPTY : mstk_pkg::OP_POP;
          end else if (action_i == mstk_pkg::ACT_POP_MAX) begin
            cmd_o.op = status_i.empty ? mstk_pkg::OP_ERR_EMPTY : mstk_pkg::OP_POP_MAX;
          end else begin
            cmd_o.op = mstk_pkg::OP_NOP;
          end
          if (cmd_o.op == mstk_pkg::OP_POP || cmd_o.op == mstk_pkg::OP_POP_MAX) begin
            state_d = mstk_pkg::ST_SEED;
          end else begin
            state_d = mstk_pkg::ST_RESP;
          end
        end
      end
      mstk_pkg::ST_SEED: begin
        cmd_o.seed = 1'b1;
        if (status_i.more) begin
          cmd_o.issue = 1'b1;
          state_d     = mstk_pkg::ST_SWEEP;
        end else begin
          state_d = mstk_pkg::ST_RESP;
        end
      end
      mstk_pkg::ST_SWEEP: begin
        cmd_o.step = 1'b1;
        if (status_i.more) begin
          cmd_o.issue = 1'b1;
        end else begin
          state_d = mstk_pkg::ST_RESP;
        end
      end
      mstk_pkg::ST_RESP: begin
        // Wait until the output register is free or being emptied.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = mstk_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = mstk_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

### sv/mstk_dp.sv
// Datapath of the max stack: entry memory, top and maximum tracking, result register.
`timescale 1ns / 1ps
`default_nettype none

module mstk_dp #(
  parameter int STACK_DEPTH = 64
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire mstk_pkg::in_t          in_i,
  input  wire mstk_pkg::ctrl_cmd_t    cmd_i,
  output mstk_pkg::dp_status_t        status_o,
  output mstk_pkg::out_t              out_o
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  // Each entry holds its value plus the maximum of itself and everything below it.
  localparam int RW = 64 + AW;

  logic [CW-1:0]      count_q, count_d;
  logic signed [31:0] top_q, top_d;
  logic signed [31:0] max_q, max_d;
  logic [AW-1:0]      maxidx_q, maxidx_d;
  logic signed [31:0] removed_q, removed_d;
  mstk_pkg::status_e  status_q, status_d;
  logic [CW-1:0]      rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]      wr_ptr_q, wr_ptr_d;
  logic               seed_q, seed_d;
  mstk_pkg::out_t     out_q;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [RW-1:0]      ram_wdata;
  logic               ram_re;
  logic [AW-1:0]      ram_raddr;
  logic [RW-1:0]      ram_rdata;

  logic signed [31:0] rd_value;
  logic signed [31:0] rd_pmax;
  logic [AW-1:0]      rd_pidx;
  logic [CW-1:0]      gap;
  logic               take;

  assign rd_value = ram_rdata[RW-1 -: 32];
  assign rd_pmax  = ram_rdata[RW-33 -: 32];
  assign rd_pidx  = ram_rdata[AW-1:0];

  mstk_ram #(
    .WIDTH (RW),
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Architectural state and result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      top_q     <= '0;
      max_q     <= '0;
      maxidx_q  <= '0;
      removed_q <= '0;
      status_q  <= mstk_pkg::STATUS_OK;
      seed_q    <= 1'b0;
    end else begin
      count_q   <= count_d;
      top_q     <= top_d;
      max_q     <= max_d;
      maxidx_q  <= maxidx_d;
      removed_q <= removed_d;
      status_q  <= status_d;
      seed_q    <= seed_d;
    end
  end

  function automatic mstk_pkg::out_t out_d();
    mstk_pkg::out_t r;
    r.removed_value = removed_q;
    r.top_value     = top_q;
    r.max_value     = max_q;
    r.fill_level    = 7'(count_q);
    r.status        = status_q;
    return r;
  endfunction

  // Sweep pointers and output register.
  always_ff @(posedge clk_i) begin
    rd_ptr_q <= rd_ptr_d;
    wr_ptr_q <= wr_ptr_d;
    if (cmd_i.out_load) begin
      out_q <= out_d();
    end
  end

  // Operation datapath.
  always_comb begin
    count_d   = count_q;
    top_d     = top_q;
    max_d     = max_q;
    maxidx_d  = maxidx_q;
    removed_d = removed_q;
    status_d  = status_q;
    rd_ptr_d  = rd_ptr_q;
    wr_ptr_d  = wr_ptr_q;
    seed_d    = seed_q;
    ram_we    = 1'b0;
    ram_waddr = count_q[AW-1:0];
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = rd_ptr_q[AW-1:0];
    gap       = count_q - CW'(1);
    take      = 1'b0;

    // Start of a transaction.
    if (cmd_i.load) begin
      removed_d = '0;
      status_d  = mstk_pkg::STATUS_OK;
      if (cmd_i.op == mstk_pkg::OP_POP_MAX) begin
        gap = CW'(maxidx_q);
      end
      unique case (cmd_i.op)
        mstk_pkg::OP_PUSH: begin
          take      = (count_q == '0) || (in_i.value >= max_q);
          ram_we    = 1'b1;
          ram_waddr = count_q[AW-1:0];
          ram_wdata = {in_i.value,
                       take ? in_i.value : max_q,
                       take ? count_q[AW-1:0] : maxidx_q};
          top_d     = in_i.value;
          max_d     = take ? in_i.value : max_q;
          maxidx_d  = take ? count_q[AW-1:0] : maxidx_q;
          count_d   = count_q + CW'(1);
        end
        mstk_pkg::OP_POP, mstk_pkg::OP_POP_MAX: begin
          removed_d = (cmd_i.op == mstk_pkg::OP_POP) ? top_q : max_q;
          count_d   = count_q - CW'(1);
          wr_ptr_d  = gap;
          rd_ptr_d  = gap + CW'(1);
          seed_d    = (gap != '0);
          ram_re    = (gap != '0);
          ram_raddr = AW'(gap - CW'(1));
        end
        mstk_pkg::OP_ERR_EMPTY: begin
          status_d = mstk_pkg::STATUS_EMPTY;
        end
        mstk_pkg::OP_ERR_FULL: begin
          status_d = mstk_pkg::STATUS_FULL;
        end
        mstk_pkg::OP_NOP: begin
          status_d = mstk_pkg::STATUS_OK;
        end
        default: begin
          status_d = mstk_pkg::STATUS_OK;
        end
      endcase
    end

    // Take the entry below the gap as the running top and maximum.
    if (cmd_i.seed) begin
      if (seed_q) begin
        top_d    = rd_value;
        max_d    = rd_pmax;
        maxidx_d = rd_pidx;
      end else begin
        top_d    = '0;
        max_d    = '0;
        maxidx_d = '0;
      end
    end

    // Move one entry down and rebuild its running maximum.
    if (cmd_i.step) begin
      take      = (wr_ptr_q == '0) || (rd_value >= max_q);
      ram_we    = 1'b1;
      ram_waddr = wr_ptr_q[AW-1:0];
      ram_wdata = {rd_value,
                   take ? rd_value : max_q,
                   take ? wr_ptr_q[AW-1:0] : maxidx_q};
      top_d     = rd_value;
      max_d     = take ? rd_value : max_q;
      maxidx_d  = take ? wr_ptr_q[AW-1:0] : maxidx_q;
      wr_ptr_d  = wr_ptr_q + CW'(1);
    end

    // Read the next entry above the gap.
    if (cmd_i.issue) begin
      ram_re    = 1'b1;
      ram_raddr = rd_ptr_q[AW-1:0];
      rd_ptr_d  = rd_ptr_q + CW'(1);
    end
  end

  assign status_o.empty = (count_q == '0);
  assign status_o.full  = (count_q == CW'(STACK_DEPTH));
  assign status_o.more  = (rd_ptr_q <= count_q);
  assign out_o          = out_q;

`ifndef ASSERT_OFF
  // An empty stack reports zero top and maximum.
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load && (count_q == '0) |-> (top_q == '0) && (max_q == '0))
    else $error("empty stack reports a nonzero top or maximum");

  // The tracked maximum sits inside the held entries.
  a_maxidx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load && (count_q != '0) |-> (CW'(maxidx_q) < count_q))
    else $error("maximum position outside the held entries");

  // During a sweep the read pointer leads the write pointer by two places.
  a_sweep_lead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> (rd_ptr_q == wr_ptr_q + CW'(2)))
    else $error("sweep read and write pointers out of step");

  // The fill count never passes the depth.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(STACK_DEPTH))
    else $error("fill count beyond stack depth");
`endif

endmodule

`default_nettype wire
